/* design/nps_pkg.sv */
package nps_pkg;

   // Default build of the table and the coordinate width
   localparam int MAX_POINTS_DEF = 16;
   localparam int COORD_BITS_DEF = 8;

   // Fixed field widths of the item formats
   localparam int INDEX_FIELD_BITS = 4;
   localparam int COORD_FIELD_BITS = 8;
   localparam int DIST_FIELD_BITS  = 17;
   localparam int CNT_BITS         = 5;

   // Packed bus widths, rounded up to whole bytes
   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = 24;

   // Field positions in req_tdata
   localparam int REQ_IDX_LSB = 0;
   localparam int REQ_X_LSB   = REQ_IDX_LSB + INDEX_FIELD_BITS;
   localparam int REQ_Y_LSB   = REQ_X_LSB + COORD_FIELD_BITS;

   // Item kinds carried in req_tuser
   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   // Reset value of the entry count
   localparam logic [CNT_BITS-1:0] COUNT_RESET = CNT_BITS'(1);

   // Per-cycle control shared by every cell of the chain
   typedef struct packed {
      logic advance;  // chain moves one cell this cycle
      logic load;     // a load item is being accepted
   } nps_ctrl_type;

endpackage

/* design/nps_cell.sv */
module nps_cell #(
   parameter int INDEX      = 0,
   parameter int COORD_BITS = nps_pkg::COORD_BITS_DEF,
   parameter int IDX_BITS   = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  nps_pkg::nps_ctrl_type               ctrl,
   input  logic [nps_pkg::CNT_BITS-1:0]        count,
   input  logic [nps_pkg::INDEX_FIELD_BITS-1:0] load_index,
   input  logic [COORD_BITS-1:0]               load_x,
   input  logic [COORD_BITS-1:0]               load_y,
   // query token from the left neighbor
   input  logic                                in_valid,
   input  logic [COORD_BITS-1:0]               in_qx,
   input  logic [COORD_BITS-1:0]               in_qy,
   input  logic [IDX_BITS-1:0]                 in_best_idx,
   input  logic [2*COORD_BITS:0]               in_best_dist,
   // query token to the right neighbor
   output logic                                out_valid,
   output logic [COORD_BITS-1:0]               out_qx,
   output logic [COORD_BITS-1:0]               out_qy,
   output logic [IDX_BITS-1:0]                 out_best_idx,
   output logic [2*COORD_BITS:0]               out_best_dist
);
   import nps_pkg::*;

   localparam logic [31:0] MY_INDEX = 32'(INDEX);
   localparam int          DIST_BITS = 2*COORD_BITS + 1;
   localparam int          SQ_BITS   = 2*COORD_BITS;

   logic [COORD_BITS-1:0]   px_ff, py_ff;
   logic                    valid_ff;
   logic [COORD_BITS-1:0]   qx_ff, qy_ff;
   logic [IDX_BITS-1:0]     idx_ff;
   logic [DIST_BITS-1:0]    dist_ff;

   logic                    load_hit;
   logic                    active;
   logic [COORD_BITS-1:0]   dx, dy;
   logic [2*COORD_BITS-1:0] sqx, sqy;
   logic [DIST_BITS-1:0]    cand_dist;
   logic                    better;
   logic [IDX_BITS-1:0]     idx_in;
   logic [DIST_BITS-1:0]    dist_in;

   // this cell holds table entry INDEX
   assign load_hit = ctrl.load && (32'(load_index) == MY_INDEX);

   always_ff @(posedge clock) begin
      if (load_hit) begin
         px_ff <= load_x;
         py_ff <= load_y;
      end
   end

   // entry zero is always searched; others only below the count
   assign active = (MY_INDEX == 32'd0) || (32'(count) > MY_INDEX);

   // squared distance of this entry to the passing query point
   always_comb begin
      dx        = (px_ff > in_qx) ? (px_ff - in_qx) : (in_qx - px_ff);
      dy        = (py_ff > in_qy) ? (py_ff - in_qy) : (in_qy - py_ff);
      sqx       = SQ_BITS'(dx) * SQ_BITS'(dx);
      sqy       = SQ_BITS'(dy) * SQ_BITS'(dy);
      cand_dist = {1'b0, sqx} + {1'b0, sqy};
      // strictly closer only, so the lower index keeps a tie
      better  = active && (cand_dist < in_best_dist);
      idx_in  = better ? IDX_BITS'(INDEX) : in_best_idx;
      dist_in = better ? cand_dist : in_best_dist;
   end

   // token valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.advance) begin
         valid_ff <= in_valid;
      end
   end

   // token payload
   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         qx_ff   <= in_qx;
         qy_ff   <= in_qy;
         idx_ff  <= idx_in;
         dist_ff <= dist_in;
      end
   end

   assign out_valid     = valid_ff;
   assign out_qx        = qx_ff;
   assign out_qy        = qy_ff;
   assign out_best_idx  = idx_ff;
   assign out_best_dist = dist_ff;

endmodule

/* design/nearest_point_search_core.sv */
// Nearest-point search over a table of MAX_POINTS reference points, held one
// entry per cell in a chain. A load item (req_tuser low) writes one entry;
// loads to an index at or above MAX_POINTS are dropped. A query item
// (req_tuser high) enters the first cell and walks the chain one cell per
// cycle while no unaccepted result on rsp stalls the chain, each cell
// comparing its point and keeping the closer one (lowest index on ties). The
// next item is taken once the query has left the last cell, so only one query
// is in the chain at a time; a load does not hold off the next item. A result
// waiting on rsp does not hold off the next item. Entries at or above
// csr_wdata's count are skipped (entry 0 is always searched). Write the count
// only while idle; reading an entry that was never loaded gives an arbitrary
// answer.
module nearest_point_search_core #(
   parameter int MAX_POINTS = nps_pkg::MAX_POINTS_DEF,
   parameter int COORD_BITS = nps_pkg::COORD_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: point_index[3:0], coord_x[11:4], coord_y[19:12], zero[23:20]
   input  logic [nps_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // req_tuser: action (0 load, 1 query)
   input  logic                               req_tuser,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // rsp_tdata: nearest_index[3:0], nearest_distance_sq[20:4], zero[23:21]
   output logic [nps_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_we,
   input  logic [nps_pkg::CNT_BITS-1:0]       csr_wdata
);
   import nps_pkg::*;

   localparam int IDX_BITS  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int DIST_BITS = 2*COORD_BITS + 1;

   logic [CNT_BITS-1:0]  count_ff;
   logic                 busy_ff;
   logic                 rsp_valid_ff;
   logic [IDX_BITS-1:0]  rsp_idx_ff;
   logic [DIST_BITS-1:0] rsp_dist_ff;

   nps_ctrl_type          ctrl;
   logic                  req_fire;
   logic                  query_fire;
   logic                  chain_done;
   logic [15:0]           x_wide, y_wide;
   logic [COORD_BITS-1:0] coord_x, coord_y;
   logic [15:0]           idx_wide;
   logic [31:0]           dist_wide;

   logic                  chain_valid [0:MAX_POINTS];
   logic [COORD_BITS-1:0] chain_qx    [0:MAX_POINTS];
   logic [COORD_BITS-1:0] chain_qy    [0:MAX_POINTS];
   logic [IDX_BITS-1:0]   chain_idx   [0:MAX_POINTS];
   logic [DIST_BITS-1:0]  chain_dist  [0:MAX_POINTS];

   // entry count register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else if (csr_we) begin
         count_ff <= csr_wdata;
      end
   end

   // input decode; only the low COORD_BITS of each coordinate count
   assign x_wide  = 16'(req_tdata[REQ_X_LSB +: COORD_FIELD_BITS]);
   assign y_wide  = 16'(req_tdata[REQ_Y_LSB +: COORD_FIELD_BITS]);
   assign coord_x = x_wide[COORD_BITS-1:0];
   assign coord_y = y_wide[COORD_BITS-1:0];

   assign req_tready = !busy_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign query_fire = req_fire && (req_tuser == ACT_QUERY);

   // chain stalls only when its result cannot move into the output register
   assign ctrl.advance = !chain_valid[MAX_POINTS] || !rsp_valid_ff || rsp_tready;
   assign ctrl.load    = req_fire && (req_tuser == ACT_LOAD);
   assign chain_done   = chain_valid[MAX_POINTS] && ctrl.advance;

   // head of the chain: query point with an empty best
   assign chain_valid[0] = query_fire;
   assign chain_qx[0]    = coord_x;
   assign chain_qy[0]    = coord_y;
   assign chain_idx[0]   = '0;
   assign chain_dist[0]  = '1;

   for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
      nps_cell #(
         .INDEX      (i),
         .COORD_BITS (COORD_BITS),
         .IDX_BITS   (IDX_BITS)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (ctrl),
         .count         (count_ff),
         .load_index    (req_tdata[REQ_IDX_LSB +: INDEX_FIELD_BITS]),
         .load_x        (coord_x),
         .load_y        (coord_y),
         .in_valid      (chain_valid[i]),
         .in_qx         (chain_qx[i]),
         .in_qy         (chain_qy[i]),
         .in_best_idx   (chain_idx[i]),
         .in_best_dist  (chain_dist[i]),
         .out_valid     (chain_valid[i+1]),
         .out_qx        (chain_qx[i+1]),
         .out_qy        (chain_qy[i+1]),
         .out_best_idx  (chain_idx[i+1]),
         .out_best_dist (chain_dist[i+1])
      );
   end

   // one query in the chain at a time
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (query_fire) begin
         busy_ff <= 1'b1;
      end else if (chain_done) begin
         busy_ff <= 1'b0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (chain_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (chain_done) begin
         rsp_idx_ff  <= chain_idx[MAX_POINTS];
         rsp_dist_ff <= chain_dist[MAX_POINTS];
      end
   end

   assign idx_wide   = 16'(rsp_idx_ff);
   assign dist_wide  = 32'(rsp_dist_ff);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {
      (RSP_DATA_BITS - INDEX_FIELD_BITS - DIST_FIELD_BITS)'(0),
      dist_wide[DIST_FIELD_BITS-1:0],
      idx_wide[INDEX_FIELD_BITS-1:0]
   };

endmodule

/* design/nps_checker.sv */
module nps_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tuser,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [nps_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready
);
   import nps_pkg::*;

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a query holds off the next item while it walks the chain
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == ACT_QUERY) |=> !req_tready)
      else $error("item taken while a query is in the chain");

   // a load on an idle block never produces a result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == ACT_LOAD && !rsp_tvalid)
      |=> !rsp_tvalid)
      else $error("result appeared after a load");

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result dropped or changed");

endmodule

bind nearest_point_search_core nps_checker u_nps_checker (.*);
